// File: src/uanf_pkg.sv
// Package for the UTF-8 name filter: widths, result type, character class table.
package uanf_pkg;

    localparam int NAME_BUF_BYTES = 64;
    localparam int CP_W           = 21;
    localparam int LEN_W          = 6;
    localparam int N_RANGES       = 31;
    localparam int OUT_TDATA_W    = 48;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_range;

    // fields from the lowest bit up: kept_count, kept_bytes, name_length, name_empty
    typedef struct packed {
        logic             name_empty;
        logic [LEN_W-1:0] name_length;
        logic [31:0]      kept_bytes;
        logic [2:0]       kept_count;
    } t_result;

    localparam int RES_W = $bits(t_result);

    localparam t_range ALNUM_RANGES [N_RANGES] = '{
        '{21'h00030, 21'h00039}, '{21'h00041, 21'h0005A}, '{21'h00061, 21'h0007A},
        '{21'h000AA, 21'h000AA}, '{21'h000B5, 21'h000B5}, '{21'h000BA, 21'h000BA},
        '{21'h000C0, 21'h000D6}, '{21'h000D8, 21'h000F6}, '{21'h000F8, 21'h002FF},
        '{21'h00370, 21'h003FF}, '{21'h00400, 21'h0052F}, '{21'h00531, 21'h00588},
        '{21'h005D0, 21'h005EA}, '{21'h00620, 21'h0064A}, '{21'h00660, 21'h00669},
        '{21'h006F0, 21'h006F9}, '{21'h00E01, 21'h00E3A}, '{21'h00E40, 21'h00E5B},
        '{21'h01E00, 21'h01FFF}, '{21'h03040, 21'h030FF}, '{21'h03131, 21'h0318E},
        '{21'h0AC00, 21'h0D7A3}, '{21'h031F0, 21'h031FF}, '{21'h03400, 21'h04DBF},
        '{21'h04E00, 21'h09FFF}, '{21'h0F900, 21'h0FAFF}, '{21'h0FF10, 21'h0FF19},
        '{21'h0FF21, 21'h0FF3A}, '{21'h0FF41, 21'h0FF5A}, '{21'h0FF66, 21'h0FFDC},
        '{21'h20000, 21'h2FA1F}
    };

    function automatic logic is_alnum(input logic [CP_W-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_RANGES; i++) begin
            hit = hit | ((cp >= ALNUM_RANGES[i].lo) && (cp <= ALNUM_RANGES[i].hi));
        end
        return hit;
    endfunction

endpackage

// File: src/utf8_alnum_name_filter_core.sv
// UTF-8 name filter: decodes a byte stream and keeps letters, digits, '-' and '_'.
//
// Channel  Dir  tdata (low bit up)                                      tlast
// s_axis   in   [7:0] in_byte                                           last_byte
// m_axis   out  [2:0] kept_count, [34:3] kept_bytes,                    name_done
//               [40:35] name_length, [41] name_empty, [47:42] zero
//
// One item per cycle while tready is high; each result is registered in the output or skid buffer.
// Decode, range compare and length check sit between the state and result registers.
// A two-entry output buffer holds results under stall; tready drops only when both are full.
// Synchronous active-low reset clears the decoder state, length and buffer valids.
module utf8_alnum_name_filter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // in_byte
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [uanf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // kept_count, kept_bytes,
                                                              // name_length, name_empty
    output logic                             o_m_axis_tlast
);

    logic [uanf_pkg::CP_W-1:0]  r_partial, n_partial;
    logic [1:0]                 r_need, n_need;
    logic [2:0]                 r_len, n_len;
    logic [23:0]                r_held, n_held;
    logic [uanf_pkg::LEN_W-1:0] r_written, n_written;

    uanf_pkg::t_result r_out, r_skid, n_res;
    logic              r_out_last, r_skid_last;
    logic              r_out_valid, r_skid_valid;

    logic in_fire, out_fire;

    logic [7:0]                b;
    logic                      cont;
    logic                      take_lead;
    logic [1:0]                pos;
    logic [31:0]               held32;
    logic [uanf_pkg::CP_W-1:0] cp_next;
    logic                      emit_req;
    logic [2:0]                emit_len;
    logic [31:0]               emit_data;
    logic [6:0]                sum;
    logic                      fits;
    logic [uanf_pkg::LEN_W-1:0] wr_after;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = r_out_valid && i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(uanf_pkg::OUT_TDATA_W - uanf_pkg::RES_W)'(0), r_out};
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        b         = i_s_axis_tdata;
        cont      = (b[7:6] == 2'b10);
        take_lead = (r_need == 2'd0) || !cont;
        pos       = r_len[1:0] - r_need;
        held32    = {8'h00, r_held} | ({24'h000000, b} << {pos, 3'b000});
        cp_next   = {r_partial[uanf_pkg::CP_W-7:0], b[5:0]};

        n_partial = r_partial;
        n_need    = r_need;
        n_len     = r_len;
        n_held    = r_held;
        emit_req  = 1'b0;
        emit_len  = 3'd0;
        emit_data = 32'h0;

        if (take_lead) begin
            n_partial = '0;
            n_need    = 2'd0;
            n_len     = 3'd0;
            n_held    = '0;
            if (b == uanf_pkg::CH_DASH || b == uanf_pkg::CH_UNDER) begin
                emit_req  = 1'b1;
                emit_len  = 3'd1;
                emit_data = {24'h000000, b};
            end else if (!b[7]) begin
                emit_req  = uanf_pkg::is_alnum({13'h0000, b});
                emit_len  = 3'd1;
                emit_data = {24'h000000, b};
            end else if (b[7:5] == 3'b110) begin
                n_partial = {16'h0000, b[4:0]};
                n_need    = 2'd1;
                n_len     = 3'd2;
                n_held    = {16'h0000, b};
            end else if (b[7:4] == 4'b1110) begin
                n_partial = {17'h00000, b[3:0]};
                n_need    = 2'd2;
                n_len     = 3'd3;
                n_held    = {16'h0000, b};
            end else if (b[7:3] == 5'b11110) begin
                n_partial = {18'h00000, b[2:0]};
                n_need    = 2'd3;
                n_len     = 3'd4;
                n_held    = {16'h0000, b};
            end
        end else begin
            n_partial = cp_next;
            n_need    = r_need - 2'd1;
            n_held    = held32[23:0];
            if (r_need == 2'd1) begin
                n_partial = '0;
                n_len     = 3'd0;
                n_held    = '0;
                emit_req  = uanf_pkg::is_alnum(cp_next);
                emit_len  = r_len;
                emit_data = held32;
            end
        end

        sum      = {1'b0, r_written} + {4'h0, emit_len};
        fits     = emit_req && (sum < 7'(uanf_pkg::NAME_BUF_BYTES));
        wr_after = fits ? sum[uanf_pkg::LEN_W-1:0] : r_written;

        n_res.kept_count  = fits ? emit_len : 3'd0;
        n_res.kept_bytes  = fits ? emit_data : 32'h0;
        n_res.name_length = wr_after;
        n_res.name_empty  = i_s_axis_tlast && (wr_after == '0);

        n_written = wr_after;
        if (i_s_axis_tlast) begin
            n_partial = '0;
            n_need    = 2'd0;
            n_len     = 3'd0;
            n_held    = '0;
            n_written = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_need    <= 2'd0;
            r_len     <= 3'd0;
            r_held    <= '0;
            r_written <= '0;
        end else if (in_fire) begin
            r_partial <= n_partial;
            r_need    <= n_need;
            r_len     <= n_len;
            r_held    <= n_held;
            r_written <= n_written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_out_last   <= r_skid_last;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= n_res;
                r_out_last  <= i_s_axis_tlast;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_res;
                r_skid_last  <= i_s_axis_tlast;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out.kept_count <= 3'd4))
        else $error("kept_count out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tlast) |=> (r_written == '0 && r_need == 2'd0))
        else $error("name state not cleared after last item");

    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.name_empty) |->
            (o_m_axis_tlast && r_out.kept_count == 3'd0 && r_out.name_length == '0))
        else $error("name_empty inconsistent with result");
`endif

endmodule

// File: test/tb_utf8_alnum_name_filter_core.sv
// Testbench for the UTF-8 name filter core: random and directed names checked against a predictor.
module tb_utf8_alnum_name_filter_core;

    typedef struct packed {
        logic       is_end;
        logic [7:0] val;
    } t_raw_item;

    typedef struct packed {
        logic              done;
        uanf_pkg::t_result r;
    } t_filtered;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [7:0]                       i_s_axis_tdata = 8'h00;  // in_byte
    logic                             i_s_axis_tlast = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [uanf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;  // kept_count, kept_bytes,
                                                       // name_length, name_empty
    logic                             o_m_axis_tlast;

    t_raw_item   raw_bytes_q[$];
    logic [7:0]  name_q[$];
    t_filtered   filtered_q[$];

    // predictor state
    logic [20:0] acc_cp = '0;
    logic [1:0]  acc_need = '0;
    logic [2:0]  acc_len = '0;
    logic [31:0] acc_held = '0;
    int          name_bytes = 0;
    int          emit_n;
    logic [31:0] emit_b;

    int n_items = 0;
    int n_results = 0;
    int n_names = 0;
    int n_kept = 0;
    int n_errors = 0;
    int total_items = 0;

    logic gaps_on = 1'b1;
    int   mode_left = 60;
    logic tail = 1'b0;

    utf8_alnum_name_filter_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // letter and digit code point spans
    function automatic void span_of(input int idx, output logic [20:0] lo,
                                    output logic [20:0] hi);
        case (idx)
            0:  {lo, hi} = {21'h00030, 21'h00039};
            1:  {lo, hi} = {21'h00041, 21'h0005A};
            2:  {lo, hi} = {21'h00061, 21'h0007A};
            3:  {lo, hi} = {21'h000AA, 21'h000AA};
            4:  {lo, hi} = {21'h000B5, 21'h000B5};
            5:  {lo, hi} = {21'h000BA, 21'h000BA};
            6:  {lo, hi} = {21'h000C0, 21'h000D6};
            7:  {lo, hi} = {21'h000D8, 21'h000F6};
            8:  {lo, hi} = {21'h000F8, 21'h002FF};
            9:  {lo, hi} = {21'h00370, 21'h003FF};
            10: {lo, hi} = {21'h00400, 21'h0052F};
            11: {lo, hi} = {21'h00531, 21'h00588};
            12: {lo, hi} = {21'h005D0, 21'h005EA};
            13: {lo, hi} = {21'h00620, 21'h0064A};
            14: {lo, hi} = {21'h00660, 21'h00669};
            15: {lo, hi} = {21'h006F0, 21'h006F9};
            16: {lo, hi} = {21'h00E01, 21'h00E3A};
            17: {lo, hi} = {21'h00E40, 21'h00E5B};
            18: {lo, hi} = {21'h01E00, 21'h01FFF};
            19: {lo, hi} = {21'h03040, 21'h030FF};
            20: {lo, hi} = {21'h03131, 21'h0318E};
            21: {lo, hi} = {21'h0AC00, 21'h0D7A3};
            22: {lo, hi} = {21'h031F0, 21'h031FF};
            23: {lo, hi} = {21'h03400, 21'h04DBF};
            24: {lo, hi} = {21'h04E00, 21'h09FFF};
            25: {lo, hi} = {21'h0F900, 21'h0FAFF};
            26: {lo, hi} = {21'h0FF10, 21'h0FF19};
            27: {lo, hi} = {21'h0FF21, 21'h0FF3A};
            28: {lo, hi} = {21'h0FF41, 21'h0FF5A};
            29: {lo, hi} = {21'h0FF66, 21'h0FFDC};
            default: {lo, hi} = {21'h20000, 21'h2FA1F};
        endcase
    endfunction

    function automatic logic letter_or_digit(input logic [20:0] cp);
        logic [20:0] lo;
        logic [20:0] hi;
        logic        hit;
        hit = 1'b0;
        for (int i = 0; i < 31; i++) begin
            span_of(i, lo, hi);
            if (cp >= lo && cp <= hi) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void clear_seq();
        acc_cp   = '0;
        acc_need = '0;
        acc_len  = '0;
        acc_held = '0;
    endfunction

    // a character is written whole only while it leaves room in the name buffer
    function automatic void try_keep(input logic [31:0] seq_bytes, input int len);
        if (name_bytes + len < uanf_pkg::NAME_BUF_BYTES) begin
            emit_n     = len;
            emit_b     = seq_bytes;
            name_bytes = name_bytes + len;
        end
    endfunction

    function automatic void filter_byte(input logic [7:0] b, input logic is_end);
        t_filtered   res;
        int          pos;
        logic [20:0] cp;
        logic [31:0] seq_bytes;
        int          seq_n;
        emit_n = 0;
        emit_b = '0;
        if (acc_need != 0 && b[7:6] != 2'b10) clear_seq();
        if (acc_need == 0) begin
            if (b == uanf_pkg::CH_DASH || b == uanf_pkg::CH_UNDER) begin
                try_keep({24'h0, b}, 1);
            end else if (!b[7]) begin
                if (letter_or_digit({13'h0, b})) try_keep({24'h0, b}, 1);
            end else if (b[7:5] == 3'b110) begin
                acc_cp   = {16'h0, b[4:0]};
                acc_need = 2'd1;
                acc_len  = 3'd2;
                acc_held = {24'h0, b};
            end else if (b[7:4] == 4'b1110) begin
                acc_cp   = {17'h0, b[3:0]};
                acc_need = 2'd2;
                acc_len  = 3'd3;
                acc_held = {24'h0, b};
            end else if (b[7:3] == 5'b11110) begin
                acc_cp   = {18'h0, b[2:0]};
                acc_need = 2'd3;
                acc_len  = 3'd4;
                acc_held = {24'h0, b};
            end
        end else begin
            pos      = int'(acc_len) - int'(acc_need);
            acc_cp   = {acc_cp[14:0], b[5:0]};
            acc_held = acc_held | ({24'h0, b} << (8 * pos));
            acc_need = acc_need - 2'd1;
            if (acc_need == 0) begin
                cp        = acc_cp;
                seq_bytes = acc_held;
                seq_n     = int'(acc_len);
                clear_seq();
                if (letter_or_digit(cp)) try_keep(seq_bytes, seq_n);
            end
        end
        res.done          = is_end;
        res.r.kept_count  = emit_n[2:0];
        res.r.kept_bytes  = emit_b;
        res.r.name_length = name_bytes[5:0];
        res.r.name_empty  = is_end && name_bytes == 0;
        filtered_q.push_back(res);
        if (is_end) begin
            clear_seq();
            name_bytes = 0;
        end
    endfunction

    function automatic int utf8_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [20:0] pick_in_span(input int first, input int last_idx);
        logic [20:0] lo;
        logic [20:0] hi;
        span_of($urandom_range(first, last_idx), lo, hi);
        return 21'($urandom_range(hi, lo));
    endfunction

    // encode cp in len bytes, push the first n of them
    task automatic push_char(input logic [20:0] cp, input int len, input int n);
        logic [7:0] enc [4];
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: enc[0] = {5'b11110, cp[20:18]};
        endcase
        for (int i = 0; i < n; i++) name_q.push_back(enc[i]);
    endtask

    task automatic push_seq(input logic [8*12-1:0] s, input int n);
        for (int i = n - 1; i >= 0; i--) name_q.push_back(s[8*i +: 8]);
    endtask

    task automatic flush_name();
        t_raw_item it;
        if (name_q.size() == 0) name_q.push_back(8'($urandom_range(0, 255)));
        foreach (name_q[i]) begin
            it.val    = name_q[i];
            it.is_end = (i == name_q.size() - 1);
            raw_bytes_q.push_back(it);
        end
        name_q.delete();
    endtask

    task automatic make_name();
        int          target;
        int          len;
        logic [20:0] cp;
        logic [20:0] lo;
        logic [20:0] hi;
        target = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 24);
        while (name_q.size() < target) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: push_char(21'($urandom_range(0, 127)), 1, 1);
                4: push_char(21'($urandom_range(0, 1) ? uanf_pkg::CH_DASH : uanf_pkg::CH_UNDER),
                             1, 1);
                5, 6: begin
                    cp = $urandom_range(0, 1) ? pick_in_span(3, 15)
                                              : 21'($urandom_range('h80, 'h7FF));
                    push_char(cp, 2, 2);
                end
                7, 8: begin
                    cp = $urandom_range(0, 1) ? pick_in_span(16, 29)
                                              : 21'($urandom_range('h800, 'hFFFF));
                    push_char(cp, 3, 3);
                end
                9: begin
                    cp = $urandom_range(0, 1) ? pick_in_span(30, 30)
                                              : 21'($urandom_range('h10000, 'h1FFFFF));
                    push_char(cp, 4, 4);
                end
                10: begin  // overlong form
                    cp  = 21'($urandom_range(0, 'h7FF));
                    len = $urandom_range(utf8_len(cp) + 1, 4);
                    push_char(cp, len, len);
                end
                11: begin  // around a span edge
                    span_of($urandom_range(0, 30), lo, hi);
                    case ($urandom_range(0, 3))
                        0: cp = lo - 21'd1;
                        1: cp = lo;
                        2: cp = hi;
                        default: cp = hi + 21'd1;
                    endcase
                    push_char(cp, utf8_len(cp), utf8_len(cp));
                end
                12: name_q.push_back(8'($urandom_range(0, 255)));
                13: begin  // truncated sequence
                    len = $urandom_range(2, 4);
                    push_char(21'($urandom_range(0, 'h1FFFFF)), len, $urandom_range(1, len - 1));
                end
                default: push_char(pick_in_span(0, 2), 1, 1);
            endcase
        end
        flush_name();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch in %s at result %0d: got %h, want %h", what, n_results, got, want);
    endtask

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            gaps_on   <= !gaps_on;
            mode_left <= $urandom_range(40, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
    end

    // sender
    always @(posedge i_clk) begin : drive
        int        send_gap;
        t_raw_item it;
        if (!i_rst_n) begin
            send_gap = 0;
            i_s_axis_tvalid <= 1'b0;
        end else begin
            tail <= raw_bytes_q.size() < 150;
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (raw_bytes_q.size() > 0 && gaps_on && !tail &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 12) - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (raw_bytes_q.size() > 0) begin
                    it = raw_bytes_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= it.val;
                    i_s_axis_tlast  <= it.is_end;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : sink
        int stall;
        if (!i_rst_n) begin
            stall = 0;
            i_m_axis_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            i_m_axis_tready <= 1'b0;
        end else if (gaps_on && !tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch
        t_filtered         want;
        uanf_pkg::t_result got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                filter_byte(i_s_axis_tdata, i_s_axis_tlast);
                n_items++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                got = o_m_axis_tdata[uanf_pkg::RES_W-1:0];
                if (filtered_q.size() == 0) begin
                    report_mismatch("result with nothing pending", got.kept_bytes, 32'h0);
                end else begin
                    want = filtered_q.pop_front();
                    if (got.kept_count != want.r.kept_count)
                        report_mismatch("kept_count", 32'(got.kept_count),
                                        32'(want.r.kept_count));
                    if (got.kept_bytes != want.r.kept_bytes)
                        report_mismatch("kept_bytes", got.kept_bytes, want.r.kept_bytes);
                    if (got.name_length != want.r.name_length)
                        report_mismatch("name_length", 32'(got.name_length),
                                        32'(want.r.name_length));
                    if (got.name_empty != want.r.name_empty)
                        report_mismatch("name_empty", 32'(got.name_empty),
                                        32'(want.r.name_empty));
                    if (o_m_axis_tlast != want.done)
                        report_mismatch("name_done", 32'(o_m_axis_tlast), 32'(want.done));
                    if (want.done) n_names++;
                    if (want.r.kept_count != 0) n_kept++;
                end
            end
        end
    end

    initial begin
        int dir_n;
        // ASCII: dash, underscore, zero byte, digit, letter, non-alnum
        push_seq(96'h2D_5F_00_30_7A_7F, 6);
        flush_name();
        // invalid leads only, so the name ends empty
        push_seq(96'h80_BF_F8_FF, 4);
        flush_name();
        // 2, 3 and 4 byte characters at span starts
        push_seq(96'hC3_80_E4_B8_80_F0_A0_80_80, 9);
        flush_name();
        // overlong 'A', dash breaking a sequence, name ending mid-sequence
        push_seq(96'hC1_81_C3_2D_E4_B8, 6);
        flush_name();
        dir_n = raw_bytes_q.size();
        while (raw_bytes_q.size() - dir_n < 1800) make_name();
        total_items = raw_bytes_q.size();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_items < total_items || filtered_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d bytes in %0d names filtered, %0d results checked, %0d with kept chars",
                 n_items, n_names, n_results, n_kept);
        if (n_errors == 0) begin
            $display("[utf8_alnum_name_filter_core] OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[utf8_alnum_name_filter_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("timeout with %0d of %0d items accepted", n_items, total_items);
        $display("[utf8_alnum_name_filter_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/uanf_pkg.sv
src/utf8_alnum_name_filter_core.sv
test/tb_utf8_alnum_name_filter_core.sv
